### hdl/embr_read_plan_generator_top_macros.svh
// Assertion macros used by the port-level checker of the read-plan generator.
// Depends on nothing; each macro expects a signal named clock and one named reset in scope.
`ifndef EMBR_READ_PLAN_GENERATOR_TOP_MACROS_SVH
`define EMBR_READ_PLAN_GENERATOR_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define EMBR_RPG_ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("read-plan generator check failed");

// Next-cycle implication, disabled while reset is high.
`define EMBR_RPG_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("read-plan generator check failed");

`endif

### hdl/embr_rpg_pkg.sv
// Package of the read-plan generator: widths, register indexes, state and command types.
// Depends on nothing.
package embr_rpg_pkg;

   localparam int MAX_NODES  = 8;
   localparam int NODE_W     = $clog2(MAX_NODES);
   localparam int NCOUNT_W   = 4;
   localparam int GROUP_W    = 3;
   localparam int SYM_W      = 5;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 5;

   typedef logic [MAX_NODES-1:0] mask_type;
   typedef logic [NODE_W-1:0]    node_type;
   typedef logic [SYM_W-1:0]     sym_type;

   localparam logic [CSR_IDX_W-1:0] CSR_NODE_COUNT     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GROUP_SIZE     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NEEDED_SYMBOLS = 2'd2;

   localparam logic [NCOUNT_W-1:0] RST_NODE_COUNT     = 4'd4;
   localparam logic [GROUP_W-1:0]  RST_GROUP_SIZE     = 3'd3;
   localparam logic [SYM_W-1:0]    RST_NEEDED_SYMBOLS = 5'd5;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_PREP,
      ST_EMIT
   } state_type;

   // Effective configuration seen by the datapath.
   typedef struct packed {
      logic [NCOUNT_W-1:0] n;
      logic [GROUP_W-1:0]  g;
      sym_type             need;
   } cfg_type;

   typedef struct packed {
      logic start;
      logic scan_step;
      logic prep;
      logic advance;
      logic emit;
      logic emit_none;
   } cmd_type;

   typedef struct packed {
      logic out_free;
      logic scan_last;
      logic mask_empty;
      logic last_pick;
      logic none;
   } status_type;

endpackage

### hdl/embr_rpg_if.sv
// Valid/ready channel interfaces of the read-plan generator: request, response and CSR write.
// Depends on embr_rpg_pkg.
interface embr_rpg_req_if;
   import embr_rpg_pkg::*;
   logic     valid;
   logic     ready;
   mask_type alive_mask;
   modport source (output valid, output alive_mask, input ready);
   modport sink (input valid, input alive_mask, output ready);
endinterface

interface embr_rpg_rsp_if;
   import embr_rpg_pkg::*;
   logic     valid;
   logic     ready;
   node_type node;
   node_type slot;
   sym_type  rs_index;
   logic     is_last;
   logic     shortfall;
   logic     none_found;
   modport source (output valid, output node, output slot, output rs_index,
                   output is_last, output shortfall, output none_found, input ready);
   modport sink (input valid, input node, input slot, input rs_index,
                 input is_last, input shortfall, input none_found, output ready);
endinterface

interface embr_rpg_csr_if;
   import embr_rpg_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

### hdl/embr_rpg_ctrl.sv
// Sequencer of the read-plan generator: scan rows, prepare the first node, emit words.
// Depends on embr_rpg_pkg.
module embr_rpg_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  embr_rpg_pkg::status_type status,
   output embr_rpg_pkg::cmd_type    cmd
);
   import embr_rpg_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.scan_last) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.none) begin
               if (status.out_free) begin
                  cmd.emit_none = 1'b1;
                  state_in      = ST_IDLE;
               end
            end else if (status.mask_empty) begin
               cmd.advance = 1'b1;
            end else if (status.out_free) begin
               cmd.emit = 1'b1;
               if (status.last_pick) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

### hdl/embr_rpg_dpath.sv
// Datapath of the read-plan generator: row scan with cutoff search, per-node pick masks,
// symbol index arithmetic and the response register. Depends on embr_rpg_pkg.
module embr_rpg_dpath (
   input  logic                     clock,
   input  logic                     reset,
   input  embr_rpg_pkg::cfg_type    cfg,
   input  embr_rpg_pkg::cmd_type    cmd,
   output embr_rpg_pkg::status_type status,
   input  embr_rpg_pkg::mask_type   alive_mask,
   input  logic                     rsp_ready,
   output logic                     rsp_valid,
   output embr_rpg_pkg::node_type   rsp_node,
   output embr_rpg_pkg::node_type   rsp_slot,
   output embr_rpg_pkg::sym_type    rsp_rs_index,
   output logic                     rsp_is_last,
   output logic                     rsp_shortfall,
   output logic                     rsp_none_found
);
   import embr_rpg_pkg::*;

   localparam int CNT_W = $clog2(MAX_NODES + 1);

   // Candidate picks met while visiting row i, indexed by the inner position.
   function automatic mask_type row_mask(input node_type i, input mask_type alive,
                                         input logic [NCOUNT_W-1:0] n,
                                         input logic [GROUP_W-1:0] g);
      mask_type m;
      m = '0;
      for (int k = 0; k < MAX_NODES; k++) begin
         if (NCOUNT_W'(i) < n) begin
            if (alive[i]) begin
               m[k] = (k >= int'(i)) && (k < int'(g));
            end else begin
               m[k] = (k > int'(i)) && (k < int'(n)) && alive[k];
            end
         end
      end
      return m;
   endfunction

   // Position of the rem-th set bit, counting from one.
   function automatic node_type nth_bit(input mask_type m, input sym_type rem);
      logic [CNT_W-1:0] acc;
      node_type         pos;
      acc = '0;
      pos = '0;
      for (int k = 0; k < MAX_NODES; k++) begin
         if (m[k]) begin
            acc = acc + 1'b1;
            if (SYM_W'(acc) == rem) begin
               pos = NODE_W'(k);
            end
         end
      end
      return pos;
   endfunction

   // Slots of node j that belong to the plan. A pick is ordered by the pair
   // (lower of node and slot, higher of node and slot), which is the visit order.
   function automatic mask_type pick_mask(input node_type j, input mask_type alive,
                                          input logic [NCOUNT_W-1:0] n,
                                          input logic [GROUP_W-1:0] g,
                                          input logic [2*NODE_W-1:0] cut,
                                          input logic full);
      mask_type            m;
      logic [2*NODE_W-1:0] key;
      logic                present;
      m = '0;
      for (int s = 0; s < MAX_NODES; s++) begin
         if (s < int'(j)) begin
            present = !alive[s];
            key     = {NODE_W'(s), j};
         end else begin
            present = s < int'(g);
            key     = {j, NODE_W'(s)};
         end
         m[s] = (NCOUNT_W'(j) < n) && alive[j] && present && (full || key <= cut);
      end
      return m;
   endfunction

   function automatic node_type lowest_bit(input mask_type m);
      node_type pos;
      pos = '0;
      for (int k = MAX_NODES - 1; k >= 0; k--) begin
         if (m[k]) begin
            pos = NODE_W'(k);
         end
      end
      return pos;
   endfunction

   // x * (x - 1) / 2
   function automatic logic [7:0] tri_num(input logic [3:0] x);
      logic [7:0] v;
      case (x)
         4'd2:    v = 8'd1;
         4'd3:    v = 8'd3;
         4'd4:    v = 8'd6;
         4'd5:    v = 8'd10;
         4'd6:    v = 8'd15;
         4'd7:    v = 8'd21;
         4'd8:    v = 8'd28;
         default: v = 8'd0;
      endcase
      return v;
   endfunction

   // Outer-code index held at (node, slot), taken modulo 32.
   function automatic sym_type rs_of(input logic [NCOUNT_W-1:0] n,
                                     input logic [GROUP_W-1:0] g,
                                     input node_type node, input node_type slot);
      logic [7:0] b;
      if (slot >= node) begin
         b = 8'(node) * 8'(g) - tri_num(4'(node)) + 8'(slot) - 8'(node);
      end else begin
         b = 8'(slot) * 8'(n) - tri_num(4'(slot) + 4'd1) + 8'(node) - 8'(slot) - 8'd1;
      end
      return b[SYM_W-1:0];
   endfunction

   mask_type            alive_ff;
   node_type            row_ff;
   sym_type             cnt_ff;
   logic [2*NODE_W-1:0] cut_ff;
   logic                full_ff;
   sym_type             total_ff;
   node_type            node_ff;
   mask_type            mask_ff;
   sym_type             sent_ff;
   logic                valid_ff;
   node_type            out_node_ff;
   node_type            out_slot_ff;
   sym_type             out_rs_ff;
   logic                out_last_ff;
   logic                out_short_ff;
   logic                out_none_ff;

   mask_type         row_bits;
   logic [CNT_W-1:0] row_pop;
   sym_type          rem;
   logic             found;
   logic             row_end;
   node_type         pick_slot;
   node_type         next_node;
   logic             out_free;

   assign row_bits  = row_mask(row_ff, alive_ff, cfg.n, cfg.g);
   assign row_pop   = CNT_W'($countones(row_bits));
   assign rem       = cfg.need - cnt_ff;
   assign found     = SYM_W'(row_pop) >= rem;
   assign row_end   = (NCOUNT_W'(row_ff) + NCOUNT_W'(1)) >= cfg.n;
   assign pick_slot = lowest_bit(mask_ff);
   assign next_node = node_ff + 1'b1;
   assign out_free  = !valid_ff || rsp_ready;

   assign status.out_free   = out_free;
   assign status.scan_last  = found || row_end;
   assign status.mask_empty = (mask_ff == '0);
   assign status.last_pick  = (sent_ff + 1'b1) == total_ff;
   assign status.none       = (total_ff == '0);

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         alive_ff <= alive_mask;
         row_ff   <= '0;
         cnt_ff   <= '0;
      end
      if (cmd.scan_step) begin
         if (found) begin
            cut_ff   <= {row_ff, nth_bit(row_bits, rem)};
            full_ff  <= 1'b0;
            total_ff <= cfg.need;
         end else if (row_end) begin
            full_ff  <= 1'b1;
            total_ff <= cnt_ff + SYM_W'(row_pop);
         end else begin
            cnt_ff <= cnt_ff + SYM_W'(row_pop);
            row_ff <= row_ff + 1'b1;
         end
      end
      if (cmd.prep) begin
         node_ff <= '0;
         sent_ff <= '0;
         mask_ff <= pick_mask('0, alive_ff, cfg.n, cfg.g, cut_ff, full_ff);
      end
      if (cmd.advance) begin
         node_ff <= next_node;
         mask_ff <= pick_mask(next_node, alive_ff, cfg.n, cfg.g, cut_ff, full_ff);
      end
      if (cmd.emit) begin
         mask_ff[pick_slot] <= 1'b0;
         sent_ff            <= sent_ff + 1'b1;
         out_node_ff        <= node_ff;
         out_slot_ff        <= pick_slot;
         out_rs_ff          <= rs_of(cfg.n, cfg.g, node_ff, pick_slot);
         out_last_ff        <= status.last_pick;
         out_short_ff       <= status.last_pick && full_ff;
         out_none_ff        <= 1'b0;
      end
      if (cmd.emit_none) begin
         out_node_ff  <= '0;
         out_slot_ff  <= '0;
         out_rs_ff    <= '0;
         out_last_ff  <= 1'b0;
         out_short_ff <= 1'b0;
         out_none_ff  <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (cmd.emit || cmd.emit_none) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_node       = out_node_ff;
   assign rsp_slot       = out_slot_ff;
   assign rsp_rs_index   = out_rs_ff;
   assign rsp_is_last    = out_last_ff;
   assign rsp_shortfall  = out_short_ff;
   assign rsp_none_found = out_none_ff;

endmodule

### hdl/embr_read_plan_generator_top.sv
// Read-plan generator top level: CSR registers, sequencer and datapath. Depends on
// embr_rpg_pkg, embr_rpg_if, embr_rpg_ctrl and embr_rpg_dpath.
// A plan holds the block through its row scans (at most 8 rows), its words (one for an
// empty plan), its node steps (at most 7) and each stalled cycle.
// Throughput: one plan at a time; the next request is taken in the cycle after the last word.
// Reset (synchronous, active high) restores node_count 4, group_size 3, needed_symbols 5.
module embr_read_plan_generator_top (
   input  logic           clock,
   input  logic           reset,
   embr_rpg_req_if.sink   req_ch,
   embr_rpg_rsp_if.source rsp_ch,
   embr_rpg_csr_if.sink   csr_ch
);
   import embr_rpg_pkg::*;

   // Configuration registers. Writes are always taken; an index past the
   // register list is dropped. The system must write only while the block is idle; no check enforces it.
   logic [NCOUNT_W-1:0] node_count_ff;
   logic [GROUP_W-1:0]  group_size_ff;
   sym_type             needed_ff;

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= RST_NODE_COUNT;
         group_size_ff <= RST_GROUP_SIZE;
         needed_ff     <= RST_NEEDED_SYMBOLS;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_NODE_COUNT:     node_count_ff <= csr_ch.data[NCOUNT_W-1:0];
            CSR_GROUP_SIZE:     group_size_ff <= csr_ch.data[GROUP_W-1:0];
            CSR_NEEDED_SYMBOLS: needed_ff     <= csr_ch.data[SYM_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // A node count above the node limit behaves as the limit itself.
   assign cfg.n    = (node_count_ff > NCOUNT_W'(MAX_NODES)) ? NCOUNT_W'(MAX_NODES)
                                                            : node_count_ff;
   assign cfg.g    = group_size_ff;
   assign cfg.need = needed_ff;

   // The sequencer takes one request at a time. It first scans node rows in
   // visit order to find where the greedy choice reaches the demand, then walks
   // the nodes in ascending order and sends each chosen slot as one word.
   embr_rpg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath keeps the alive mask, the cutoff found by the scan, the
   // current node's remaining slots and the response register, which lets a
   // new request in while the final word still waits downstream.
   embr_rpg_dpath u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .cmd            (cmd),
      .status         (status),
      .alive_mask     (req_ch.alive_mask),
      .rsp_ready      (rsp_ch.ready),
      .rsp_valid      (rsp_ch.valid),
      .rsp_node       (rsp_ch.node),
      .rsp_slot       (rsp_ch.slot),
      .rsp_rs_index   (rsp_ch.rs_index),
      .rsp_is_last    (rsp_ch.is_last),
      .rsp_shortfall  (rsp_ch.shortfall),
      .rsp_none_found (rsp_ch.none_found)
   );

endmodule

### hdl/embr_rpg_checker.sv
// Port-level checker of the read-plan generator and its bind to the top level.
// Depends on embr_rpg_pkg and embr_read_plan_generator_top_macros.svh.
`include "embr_read_plan_generator_top_macros.svh"

module embr_rpg_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input embr_rpg_pkg::node_type rsp_node,
   input embr_rpg_pkg::node_type rsp_slot,
   input embr_rpg_pkg::sym_type  rsp_rs_index,
   input logic                   rsp_is_last,
   input logic                   rsp_shortfall,
   input logic                   rsp_none_found
);
   import embr_rpg_pkg::*;

   logic                        none_fields_zero;
   logic [2*NODE_W+SYM_W+2:0]   rsp_word;

   assign none_fields_zero = (rsp_node == '0) && (rsp_slot == '0) && (rsp_rs_index == '0) &&
                             !rsp_is_last && !rsp_shortfall;
   assign rsp_word = {rsp_node, rsp_slot, rsp_rs_index, rsp_is_last, rsp_shortfall,
                      rsp_none_found};

   // An empty plan is reported by a single clean word.
   `EMBR_RPG_ASSERT_IMPL(a_none_clean, rsp_valid && rsp_none_found, none_fields_zero)
   // A shortfall is flagged only on the closing word.
   `EMBR_RPG_ASSERT_IMPL(a_short_last, rsp_valid && rsp_shortfall, rsp_is_last && !rsp_none_found)
   // Only one request is in work at a time.
   `EMBR_RPG_ASSERT_NEXT(a_one_req, req_valid && req_ready, !req_ready)
   // A stalled response word holds.
   `EMBR_RPG_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_word))

endmodule

bind embr_read_plan_generator_top embr_rpg_checker u_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_ch.valid),
   .req_ready      (req_ch.ready),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_node       (rsp_ch.node),
   .rsp_slot       (rsp_ch.slot),
   .rsp_rs_index   (rsp_ch.rs_index),
   .rsp_is_last    (rsp_ch.is_last),
   .rsp_shortfall  (rsp_ch.shortfall),
   .rsp_none_found (rsp_ch.none_found)
);

### test/embr_rpg_checker.sv
// Scoreboard for the read-plan generator: watches the request, response and CSR channels,
// predicts every plan word and compares it. Depends on embr_rpg_pkg and embr_rpg_if.
module embr_rpg_scoreboard (
   input  logic    clock,
   input  logic    reset,
   embr_rpg_req_if req_ch,
   embr_rpg_rsp_if rsp_ch,
   embr_rpg_csr_if csr_ch,
   output int      mismatches,
   output int      words_pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import embr_rpg_pkg::*;

   typedef struct packed {
      node_type node;
      node_type slot;
      sym_type  rs_index;
      logic     is_last;
      logic     shortfall;
      logic     none_found;
   } read_pick_type;

   cfg_type       plan_cfg;
   read_pick_type pick_queue[$];

   // Outer-code index held in a given slot of a given node, truncated to the field width.
   function automatic sym_type symbol_index(int n, int g, int nd, int sl);
      int base;
      base = 0;
      if (sl >= nd) begin
         for (int i = 1; i <= nd; i++) base += g - (i - 1);
         return sym_type'(base + sl - nd);
      end
      for (int i = 1; i <= sl; i++) base += n - i;
      return sym_type'(base + nd - sl - 1);
   endfunction

   // Greedy pick over the nodes, then the words grouped per node in ascending order.
   function automatic void plan_reads(mask_type alive);
      int            picks[MAX_NODES][MAX_NODES];
      int            npick[MAX_NODES];
      int            n, g, need, count;
      read_pick_type plan[$];
      read_pick_type w;
      n     = (plan_cfg.n > MAX_NODES) ? MAX_NODES : int'(plan_cfg.n);
      g     = int'(plan_cfg.g);
      need  = int'(plan_cfg.need);
      count = 0;
      foreach (npick[i]) npick[i] = 0;
      for (int i = 0; i < n && count < need; i++) begin
         if (!alive[i]) begin
            for (int j = i + 1; j < n && count < need; j++) begin
               if (alive[j]) begin
                  if (npick[j] < MAX_NODES) begin
                     picks[j][npick[j]] = i;
                     npick[j]++;
                  end
                  count++;
               end
            end
         end else begin
            for (int j = i; j < g && count < need; j++) begin
               if (npick[i] < MAX_NODES) begin
                  picks[i][npick[i]] = j;
                  npick[i]++;
               end
               count++;
            end
         end
      end
      for (int i = 0; i < n; i++) begin
         for (int j = 0; j < npick[i] && plan.size() < 28; j++) begin
            w            = '0;
            w.node       = node_type'(i);
            w.slot       = node_type'(picks[i][j]);
            w.rs_index   = symbol_index(n, g, i, picks[i][j]);
            plan         = {plan, w};
         end
      end
      if (plan.size() == 0) begin
         w            = '0;
         w.none_found = 1'b1;
         plan         = {plan, w};
      end else begin
         plan[plan.size() - 1].is_last   = 1'b1;
         plan[plan.size() - 1].shortfall = (count < need);
      end
      foreach (plan[k]) pick_queue = {pick_queue, plan[k]};
   endfunction

   function automatic void check_field(string name, int want, int got);
      if (want != got) begin
         mismatches++;
         $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      end
   endfunction

   always @(posedge clock) begin
      read_pick_type want;
      if (reset) begin
         plan_cfg.n    = RST_NODE_COUNT;
         plan_cfg.g    = RST_GROUP_SIZE;
         plan_cfg.need = RST_NEEDED_SYMBOLS;
         pick_queue.delete();
         mismatches = 0;
      end else begin
         if (req_ch.valid && req_ch.ready) plan_reads(req_ch.alive_mask);
         if (csr_ch.valid && csr_ch.ready) begin
            case (csr_ch.index)
               CSR_NODE_COUNT:     plan_cfg.n    = csr_ch.data[NCOUNT_W-1:0];
               CSR_GROUP_SIZE:     plan_cfg.g    = csr_ch.data[GROUP_W-1:0];
               CSR_NEEDED_SYMBOLS: plan_cfg.need = csr_ch.data[SYM_W-1:0];
               default: ;
            endcase
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (pick_queue.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected word node %0d slot %0d rs_index %0d flags %b%b%b",
                        $time, rsp_ch.node, rsp_ch.slot, rsp_ch.rs_index,
                        rsp_ch.is_last, rsp_ch.shortfall, rsp_ch.none_found);
            end else begin
               want = pick_queue.pop_front();
               check_field("node", want.node, rsp_ch.node);
               check_field("slot", want.slot, rsp_ch.slot);
               check_field("rs_index", want.rs_index, rsp_ch.rs_index);
               check_field("is_last", want.is_last, rsp_ch.is_last);
               check_field("shortfall", want.shortfall, rsp_ch.shortfall);
               check_field("none_found", want.none_found, rsp_ch.none_found);
            end
         end
      end
      words_pending = pick_queue.size();
   end

endmodule

### test/tb.sv
// Top of the read-plan generator testbench: clock, reset, stimulus and the final verdict.
// Depends on embr_rpg_pkg, embr_rpg_if, embr_rpg_scoreboard and embr_read_plan_generator_top.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import embr_rpg_pkg::*;

   // Length of the deliberate response back-pressure, in cycles.
   localparam int HOLD_CYCLES   = 400;
   // Cycles with no word moving on any channel before the run is declared hung.
   localparam int STALL_LIMIT   = 5000;
   // Quiet cycles after the last expected word before touching the registers or ending.
   localparam int SETTLE_CYCLES = 8;

   logic clock = 1'b0;
   logic reset = 1'b1;

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int hold_requests  = 0;
   int quiet_cycles   = 0;
   int mismatches;
   int words_pending;

   embr_rpg_req_if req_ch ();
   embr_rpg_rsp_if rsp_ch ();
   embr_rpg_csr_if csr_ch ();

   embr_read_plan_generator_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // The checker sees the same channels and keeps its own copy of the registers.
   embr_rpg_scoreboard plan_check (
      .clock         (clock),
      .reset         (reset),
      .req_ch        (req_ch),
      .rsp_ch        (rsp_ch),
      .csr_ch        (csr_ch),
      .mismatches    (mismatches),
      .words_pending (words_pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Response side. Ready is redrawn every cycle from the current stall rate. When the
   // stimulus asks for a hold, ready stays low for a long stretch so that the block fills
   // up and stops taking requests while the sender keeps offering them.
   initial begin
      int holds_done;
      holds_done   = 0;
      rsp_ch.ready = 1'b0;
      @(posedge clock);
      forever begin
         if (hold_requests != holds_done) begin
            holds_done++;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
            @(posedge clock);
         end
      end
   end

   // Hang detector: any cycle in which a word moves on any channel restarts the count.
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
                   (csr_ch.valid && csr_ch.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("embr_read_plan_generator_top verification failed");
            $finish;
         end
      end
   end

   // Offer one alive mask, after a random number of idle cycles, and return on the edge
   // at which it is accepted. Valid is left high so back-to-back requests need no gap.
   task automatic send_plan(input mask_type alive);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.alive_mask <= alive;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // One register write; the caller lowers valid after the last write of a group.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= CSR_DATA_W'(value);
      do @(posedge clock); while (!csr_ch.ready);
   endtask

   // Stop requesting and wait until every predicted word has come back. Sampling at the
   // falling edge sees the checker's bookkeeping of the rising edge before it.
   task automatic drain();
      req_ch.valid <= 1'b0;
      do @(negedge clock); while (words_pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Registers only change while the block is idle.
   task automatic set_config(input int nodes, input int group, input int need);
      drain();
      write_reg(CSR_NODE_COUNT, nodes);
      write_reg(CSR_GROUP_SIZE, group);
      write_reg(CSR_NEEDED_SYMBOLS, need);
      csr_ch.valid <= 1'b0;
   endtask

   // Mostly a consistent geometry (group size one less than the node count) with a demand
   // the nodes can meet; now and then any value the registers can hold.
   task automatic random_config();
      int nodes, used, group, need, full;
      nodes = ($urandom_range(5) == 0) ? $urandom_range(15) : $urandom_range(8, 2);
      used  = (nodes > MAX_NODES) ? MAX_NODES : nodes;
      group = ($urandom_range(3) == 0) ? $urandom_range(7) : ((used < 1) ? 0 : used - 1);
      full  = used * (used - 1) / 2;
      need  = ($urandom_range(3) == 0) ? $urandom_range(31)
                                        : $urandom_range(1, (full > 1) ? full : 1);
      set_config(nodes, group, need);
   endtask

   // Most masks lose only a node or two, which is where the repair path gets exercised;
   // the rest are arbitrary.
   function automatic mask_type random_mask();
      mask_type alive;
      if ($urandom_range(2) == 0) return mask_type'($urandom_range(255));
      alive = '1;
      repeat ($urandom_range(2)) alive[$urandom_range(MAX_NODES - 1)] = 1'b0;
      return alive;
   endfunction

   initial begin
      mask_type reset_masks[9];
      reset_masks = '{8'h00, 8'hFF, 8'h0F, 8'h01, 8'h08, 8'h0E, 8'hF0, 8'hAA, 8'h55};
      req_ch.valid      = 1'b0;
      req_ch.alive_mask = '0;
      csr_ch.valid      = 1'b0;
      csr_ch.index      = CSR_NODE_COUNT;
      csr_ch.data       = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed part. First the register values left by reset: no node, all nodes,
      // single survivors and alternating failures.
      foreach (reset_masks[k]) send_plan(reset_masks[k]);

      // Full eight-node triangle: every slot and the highest symbol index, then the
      // repair path for a failed first and last node, and nothing alive at all.
      set_config(8, 7, 28);
      send_plan(8'hFF);
      send_plan(8'hFE);
      send_plan(8'h7F);
      send_plan(8'h00);

      // Demand beyond what the nodes can hold: the last word flags the shortfall.
      set_config(8, 7, 31);
      send_plan(8'hFF);

      // A node count of zero gives no picks; with one node only the first node's own
      // slots are read.
      set_config(0, 3, 5);
      send_plan(8'hFF);
      set_config(1, 3, 5);
      send_plan(8'hFF);

      // A node count above the maximum behaves as the maximum.
      set_config(15, 7, 20);
      send_plan(8'hB7);

      // Zero demand reports nothing found.
      set_config(4, 3, 0);
      send_plan(8'hFF);

      // Group sizes that disagree with the node count: no slots at all, and more slots than nodes.
      set_config(5, 0, 10);
      send_plan(8'hFF);
      send_plan(8'h13);
      set_config(3, 7, 20);
      send_plan(8'h07);
      send_plan(8'h02);

      // Random part in four handshake regimes: free flowing, sparse requests, a slow
      // response side, and occasional gaps on both. Each regime runs three register
      // settings; the last setting of the first regime starts with the long hold-off.
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct  = 87;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct  = 0;
               recv_stall_pct = 87;
            end
            default: begin
               send_idle_pct  = 19;
               recv_stall_pct = 19;
            end
         endcase
         for (int blk = 0; blk < 3; blk++) begin
            random_config();
            if (phase == 0 && blk == 2) hold_requests++;
            repeat (12) send_plan(random_mask());
         end
      end

      drain();
      if (mismatches == 0 && words_pending == 0) begin
         $display("embr_read_plan_generator_top verification clean");
      end else begin
         $display("embr_read_plan_generator_top verification failed");
      end
      $finish;
   end

endmodule
